@@ src/mwe_pkg.sv @@
// ---------------------------------------------------------------------------
// Microwire EEPROM master package
// Request codes, command opcodes, sequencer stages, status codes and the
// item types passed between the register stages and the sequencer.
// ---------------------------------------------------------------------------
package mwe_pkg;

	localparam int FUNC_W   = 3;
	localparam int ADDR_W   = 8;
	localparam int WDATA_W  = 16;
	localparam int RDATA_W  = 16;
	localparam int STATUS_W = 2;
	localparam int POLL_W   = 16;
	localparam int CMD_W    = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK  = 3'd0,
		FN_READ  = 3'd1,
		FN_WRITE = 3'd2,
		FN_ERASE = 3'd3,
		FN_WEN   = 3'd4,
		FN_WDS   = 3'd5
	} func_t;

	// Start bit followed by the two opcode bits.
	localparam logic [CMD_W-1:0] CMD_READ  = 3'b110;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'b101;
	localparam logic [CMD_W-1:0] CMD_ERASE = 3'b111;
	localparam logic [CMD_W-1:0] CMD_WEN   = 3'b100;

	typedef enum logic [2:0] {
		SEQ_IDLE  = 3'd0,
		SEQ_OUT   = 3'd1,
		SEQ_IN    = 3'd2,
		SEQ_TRAIL = 3'd3,
		SEQ_DESEL = 3'd4,
		SEQ_POLL  = 3'd5,
		SEQ_END   = 3'd6
	} stage_t;

	localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STS_TIMEOUT = 2'd1;
	localparam logic [STATUS_W-1:0] STS_REFUSED = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [ADDR_W-1:0]  addr;
		logic [WDATA_W-1:0] wdata;
		logic               miso;
	} req_item_t;

	typedef struct packed {
		logic                cs;
		logic                sk;
		logic                di;
		logic                busy_res;
		logic                done_res;
		logic [RDATA_W-1:0]  rdata;
		logic [STATUS_W-1:0] status;
	} res_item_t;

endpackage

@@ src/mwe_if.sv @@
// ---------------------------------------------------------------------------
// Microwire EEPROM master channel interfaces
// Request, result and configuration channels, each with valid and ready.
// ---------------------------------------------------------------------------
interface mwe_req_if import mwe_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [ADDR_W-1:0]  addr;
	logic [WDATA_W-1:0] wdata;
	logic               miso;

	modport source (output valid, func, addr, wdata, miso, input ready);
	modport sink   (input valid, func, addr, wdata, miso, output ready);
endinterface

interface mwe_res_if import mwe_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                cs;
	logic                sk;
	logic                di;
	logic                busy_res;
	logic                done_res;
	logic [RDATA_W-1:0]  rdata;
	logic [STATUS_W-1:0] status;

	modport source (output valid, cs, sk, di, busy_res, done_res, rdata, status,
		input ready);
	modport sink   (input valid, cs, sk, di, busy_res, done_res, rdata, status,
		output ready);
endinterface

interface mwe_cfg_if import mwe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [POLL_W-1:0] poll_limit;

	modport source (output valid, poll_limit, input ready);
	modport sink   (input valid, poll_limit, output ready);
endinterface

@@ src/mwe_seq.sv @@
// ---------------------------------------------------------------------------
// Microwire EEPROM master sequencer
// Holds the bus state and, for each enabled step, works out the pin levels
// and status of one clock phase and the state after it.
// ---------------------------------------------------------------------------
module mwe_seq import mwe_pkg::*; #(
	parameter int ADDR_BITS = 8,
	parameter int DATA_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  req_item_t         item,
	input  logic [POLL_W-1:0] poll_limit,
	output res_item_t         res
);

	localparam int SHIFT_W = CMD_W + ADDR_BITS + DATA_BITS;
	localparam int BL_W    = $clog2(SHIFT_W + 1);
	localparam int IDX_W   = $clog2(SHIFT_W);

	stage_t               stage_q, stage_d;
	func_t                op_q, op_d;
	logic [SHIFT_W-1:0]   shift_q, shift_d;
	logic [BL_W-1:0]      bl_q, bl_d;
	logic                 phase_q, phase_d;
	logic [DATA_BITS-1:0] in_q, in_d;
	logic [POLL_W-1:0]    pc_q, pc_d;

	func_t                func;
	logic                 is_req;
	logic [BL_W-1:0]      bl_dec;
	logic                 bit_cur, bit_dec;
	logic [CMD_W-1:0]     cmd;
	logic [ADDR_BITS-1:0] addr_use;
	logic                 poll_expired;

	assign func    = func_t'(item.func);
	assign is_req  = (item.func >= FN_READ) && (item.func <= FN_WDS);
	assign bl_dec  = (bl_q != '0) ? bl_q - 1'b1 : bl_q;
	assign bit_cur = (bl_q != '0) && shift_q[IDX_W'(bl_q - 1'b1)];
	assign bit_dec = (bl_dec != '0) && shift_q[IDX_W'(bl_dec - 1'b1)];
	assign poll_expired = (pc_q >= poll_limit);

	always_comb begin
		cmd      = CMD_WEN;
		addr_use = ADDR_BITS'(item.addr);
		case (func)
			FN_READ:  cmd = CMD_READ;
			FN_WRITE: cmd = CMD_WRITE;
			FN_ERASE: cmd = CMD_ERASE;
			FN_WEN:   addr_use = '1;
			default:  addr_use = '0;
		endcase
	end

	// Next state.
	always_comb begin
		stage_d = stage_q;
		op_d    = op_q;
		shift_d = shift_q;
		bl_d    = bl_q;
		phase_d = phase_q;
		in_d    = in_q;
		pc_d    = pc_q;
		unique case (stage_q)
			SEQ_IDLE: begin
				if (is_req) begin
					if (func == FN_WRITE) begin
						shift_d = {cmd, addr_use, item.wdata[DATA_BITS-1:0]};
						bl_d    = BL_W'(SHIFT_W);
					end else begin
						shift_d = SHIFT_W'({cmd, addr_use});
						bl_d    = BL_W'(CMD_W + ADDR_BITS);
					end
					op_d    = func;
					stage_d = SEQ_OUT;
					phase_d = 1'b0;
					in_d    = '0;
					pc_d    = '0;
				end
			end
			SEQ_OUT: begin
				phase_d = !phase_q;
				if (phase_q) begin
					bl_d = bl_dec;
					if (bl_dec == '0) begin
						if (op_q == FN_READ) begin
							stage_d = SEQ_IN;
							bl_d    = BL_W'(DATA_BITS);
						end else if (op_q == FN_WRITE || op_q == FN_ERASE) begin
							stage_d = SEQ_DESEL;
						end else begin
							stage_d = SEQ_END;
						end
					end
				end
			end
			SEQ_IN: begin
				phase_d = !phase_q;
				if (phase_q) begin
					in_d = {in_q[DATA_BITS-2:0], item.miso};
					bl_d = bl_dec;
					if (bl_dec == '0) begin
						stage_d = SEQ_TRAIL;
					end
				end
			end
			SEQ_TRAIL: begin
				phase_d = !phase_q;
				if (phase_q) begin
					stage_d = SEQ_END;
				end
			end
			SEQ_DESEL: begin
				phase_d = !phase_q;
				if (phase_q) begin
					stage_d = SEQ_POLL;
				end
			end
			SEQ_POLL: begin
				if (phase_q) begin
					phase_d = 1'b0;
				end else if (item.miso || poll_expired) begin
					stage_d = SEQ_IDLE;
					op_d    = FN_TICK;
					bl_d    = '0;
				end else begin
					pc_d    = pc_q + 1'b1;
					phase_d = 1'b1;
				end
			end
			SEQ_END: begin
				stage_d = SEQ_IDLE;
				op_d    = FN_TICK;
				phase_d = 1'b0;
				bl_d    = '0;
			end
			default: begin
				stage_d = SEQ_IDLE;
				op_d    = FN_TICK;
				phase_d = 1'b0;
				bl_d    = '0;
			end
		endcase
	end

	// Pin levels and status of this phase.
	always_comb begin
		res          = '0;
		res.status   = STS_OK;
		unique case (stage_q) inside
			SEQ_IDLE: begin
				if (is_req) begin
					res.cs = 1'b1;
					res.di = 1'b1;
				end
			end
			SEQ_OUT: begin
				res.cs = 1'b1;
				if (!phase_q) begin
					res.sk = 1'b1;
					res.di = bit_cur;
				end else begin
					res.di = bit_dec;
				end
			end
			SEQ_IN, SEQ_TRAIL: begin
				res.cs = 1'b1;
				res.sk = !phase_q;
			end
			SEQ_DESEL: begin
				res.sk = !phase_q;
			end
			SEQ_POLL: begin
				if (phase_q) begin
					res.cs = 1'b1;
				end else if (item.miso) begin
					res.done_res = 1'b1;
				end else if (poll_expired) begin
					res.done_res = 1'b1;
					res.status   = STS_TIMEOUT;
				end else begin
					res.cs = 1'b1;
					res.sk = 1'b1;
				end
			end
			SEQ_END: begin
				res.done_res = 1'b1;
				if (op_q == FN_READ) begin
					res.rdata = RDATA_W'(in_q);
				end
			end
			default: begin
				res.cs = 1'b0;
			end
		endcase
		res.busy_res = (stage_d != SEQ_IDLE);
		// A request that arrives mid-operation is dropped, and flagged unless it falls on a finishing phase.
		if (is_req && stage_q != SEQ_IDLE && !res.done_res) begin
			res.status = STS_REFUSED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= SEQ_IDLE;
			op_q    <= FN_TICK;
			shift_q <= '0;
			bl_q    <= '0;
			phase_q <= 1'b0;
			in_q    <= '0;
			pc_q    <= '0;
		end else if (step_en) begin
			stage_q <= stage_d;
			op_q    <= op_d;
			shift_q <= shift_d;
			bl_q    <= bl_d;
			phase_q <= phase_d;
			in_q    <= in_d;
			pc_q    <= pc_d;
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == SEQ_IDLE) |-> (bl_q == '0 && !phase_q))
		else $error("sequencer idle with bits or phase left over");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && res.done_res) |=> (stage_q == SEQ_IDLE))
		else $error("sequencer not idle after a finishing step");

	a_poll_op: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == SEQ_POLL || stage_q == SEQ_DESEL) |->
		(op_q == FN_WRITE || op_q == FN_ERASE))
		else $error("ready poll entered for an operation without programming");

	a_done_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && res.done_res) |-> (!res.cs && !res.sk && !res.busy_res))
		else $error("pins not released on a finishing step");

endmodule

@@ src/microwire_eeprom_master_core.sv @@
// ---------------------------------------------------------------------------
// Microwire EEPROM master core
// Request register, bus sequencer and result register.
// ---------------------------------------------------------------------------
// Each request item is one phase of the serial clock: func 0 is a plain tick,
// func 1 to 5 start a read, write, erase, write enable or write disable when
// the master is idle. Every item gives exactly one result item carrying the
// CS, SK and DI pin levels for that phase, busy and done flags, the read word
// on the finishing phase of a read, and a status (ok, timeout, refused).
// The cfg channel writes the ready-poll limit; it is always ready and should
// only be written while no request is in flight.
// From request acceptance to result valid an item passes through the request
// register and then the result register. One item is accepted per cycle while
// the result side is not stalled; the sequencer state advances once per item as
// it moves from the request register into the result register.
// When the result receiver stalls, the result register holds, the request
// register fills and req.ready falls until the result is taken.
// Reset clears the sequencer to idle, empties both registers and sets the
// poll limit to 65535.
// ---------------------------------------------------------------------------
module microwire_eeprom_master_core import mwe_pkg::*; #(
	parameter int ADDR_BITS = 8,
	parameter int DATA_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	mwe_req_if.sink   req,
	mwe_res_if.source res,
	mwe_cfg_if.sink   cfg
);

	logic              valid_s1;
	req_item_t         item_s1;
	logic              res_valid_q;
	res_item_t         res_q;
	res_item_t         res_d;
	logic [POLL_W-1:0] poll_limit_q;
	logic              advance;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= '1;
		end else if (cfg.valid) begin
			poll_limit_q <= cfg.poll_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{func: req.func, addr: req.addr, wdata: req.wdata,
				miso: req.miso};
		end
	end

	mwe_seq #(
		.ADDR_BITS (ADDR_BITS),
		.DATA_BITS (DATA_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.item       (item_s1),
		.poll_limit (poll_limit_q),
		.res        (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.cs       = res_q.cs;
	assign res.sk       = res_q.sk;
	assign res.di       = res_q.di;
	assign res.busy_res = res_q.busy_res;
	assign res.done_res = res_q.done_res;
	assign res.rdata    = res_q.rdata;
	assign res.status   = res_q.status;

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result register empty after a step");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && !req.ready) |-> (valid_s1 && res_valid_q && !res.ready))
		else $error("request refused without a stalled result");

endmodule

@@ verif/microwire_eeprom_master_core_tb.sv @@
// ---------------------------------------------------------------------------
// Microwire EEPROM master core testbench
// Drives clock-phase requests into the core and checks every result item
// against a cycle-true model of the pin sequencer. Operations are planned
// on a separate copy of that model, so read data and ready polls line up with
// the phases the core is in. Both channels idle at random, and the poll
// limit is changed between phases.
// ---------------------------------------------------------------------------
module microwire_eeprom_master_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mwe_pkg::*;

	localparam int OUT_W = CMD_W + ADDR_W + WDATA_W;
	localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

	typedef enum {MISO_RANDOM, MISO_HIGH, MISO_LOW} miso_plan_t;

	typedef struct packed {
		stage_t             stage;
		logic [FUNC_W-1:0]  op;
		logic [OUT_W-1:0]   out_bits;
		logic [4:0]         bits_left;
		logic               sk_high;
		logic [RDATA_W-1:0] in_bits;
		logic [POLL_W-1:0]  polls;
	} bus_state_t;

	typedef struct {
		req_item_t   item;
		int unsigned gap;
		bit          hold_for_drain;
	} queued_req_t;

	logic clk;
	logic arst_n;

	mwe_req_if req_ch ();
	mwe_res_if res_ch ();
	mwe_cfg_if cfg_ch ();

	microwire_eeprom_master_core #(
		.ADDR_BITS(ADDR_W),
		.DATA_BITS(WDATA_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	queued_req_t       pending_reqs[$];
	res_item_t         bus_phase_expected[int unsigned];
	bus_state_t        plan_bus;
	bus_state_t        live_bus;
	logic [POLL_W-1:0] poll_limit_set;
	int unsigned       planned;
	int unsigned       phases_predicted;
	int unsigned       phases_checked;
	int unsigned       gap_waited;
	int unsigned       rx_hold;
	int unsigned       mismatches;
	bit                tx_calm;
	bit                rx_calm;
	bit                next_drain;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// One serial clock phase of the sequencer, with the outputs it drives.
	function automatic res_item_t predict_bus_phase(inout bus_state_t s,
			input logic [POLL_W-1:0] limit, input req_item_t q);
		res_item_t         r;
		logic              is_req;
		logic              refused;
		logic              finish;
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] a;
		r = '0;
		is_req = (q.func >= FN_READ) && (q.func <= FN_WDS);
		refused = 1'b0;
		finish = 1'b0;
		if (s.stage == SEQ_IDLE) begin
			if (is_req) begin
				a = q.addr;
				case (q.func)
				FN_READ: cmd = CMD_READ;
				FN_WRITE: cmd = CMD_WRITE;
				FN_ERASE: cmd = CMD_ERASE;
				default: begin
					// Enable and disable share one opcode and differ in the address.
					cmd = CMD_WEN;
					a = (q.func == FN_WEN) ? '1 : '0;
				end
				endcase
				s.out_bits = {{WDATA_W{1'b0}}, cmd, a};
				s.bits_left = 5'(CMD_W + ADDR_W);
				if (q.func == FN_WRITE) begin
					s.out_bits = {cmd, a, q.wdata};
					s.bits_left = 5'(OUT_W);
				end
				s.op = q.func;
				s.stage = SEQ_OUT;
				s.sk_high = 1'b0;
				s.in_bits = '0;
				s.polls = '0;
				r.cs = 1'b1;
				r.di = s.out_bits[s.bits_left - 1'b1];
			end
		end else begin
			refused = is_req;
			case (s.stage)
			SEQ_OUT: begin
				r.cs = 1'b1;
				if (!s.sk_high) begin
					r.sk = 1'b1;
					r.di = s.out_bits[s.bits_left - 1'b1];
					s.sk_high = 1'b1;
				end else begin
					s.sk_high = 1'b0;
					if (s.bits_left != 0) s.bits_left = s.bits_left - 1'b1;
					if (s.bits_left != 0) r.di = s.out_bits[s.bits_left - 1'b1];
					else if (s.op == FN_READ) begin
						s.stage = SEQ_IN;
						s.bits_left = 5'(WDATA_W);
					end else if (s.op == FN_WRITE || s.op == FN_ERASE) s.stage = SEQ_DESEL;
					else s.stage = SEQ_END;
				end
			end
			SEQ_IN: begin
				r.cs = 1'b1;
				if (!s.sk_high) begin
					r.sk = 1'b1;
					s.sk_high = 1'b1;
				end else begin
					s.sk_high = 1'b0;
					s.in_bits = {s.in_bits[RDATA_W-2:0], q.miso};
					if (s.bits_left != 0) s.bits_left = s.bits_left - 1'b1;
					if (s.bits_left == 0) s.stage = SEQ_TRAIL;
				end
			end
			SEQ_TRAIL: begin
				r.cs = 1'b1;
				if (!s.sk_high) begin
					r.sk = 1'b1;
					s.sk_high = 1'b1;
				end else begin
					s.sk_high = 1'b0;
					s.stage = SEQ_END;
				end
			end
			SEQ_DESEL: begin
				if (!s.sk_high) begin
					r.sk = 1'b1;
					s.sk_high = 1'b1;
				end else begin
					s.sk_high = 1'b0;
					s.stage = SEQ_POLL;
				end
			end
			SEQ_POLL: begin
				if (s.sk_high) begin
					r.cs = 1'b1;
					s.sk_high = 1'b0;
				end else if (q.miso) begin
					r.done_res = 1'b1;
					finish = 1'b1;
				end else if (s.polls >= limit) begin
					r.done_res = 1'b1;
					r.status = STS_TIMEOUT;
					finish = 1'b1;
				end else begin
					r.cs = 1'b1;
					r.sk = 1'b1;
					s.polls = s.polls + 1'b1;
					s.sk_high = 1'b1;
				end
			end
			SEQ_END: begin
				r.done_res = 1'b1;
				if (s.op == FN_READ) r.rdata = s.in_bits;
				finish = 1'b1;
			end
			default: finish = 1'b1;
			endcase
		end
		if (finish) begin
			s.op = FN_TICK;
			s.stage = SEQ_IDLE;
			s.sk_high = 1'b0;
			s.bits_left = '0;
		end
		r.busy_res = (s.stage != SEQ_IDLE);
		if (refused && !r.done_res) r.status = STS_REFUSED;
		return r;
	endfunction

	function automatic void plan_push(req_item_t q);
		queued_req_t e;
		void'(predict_bus_phase(plan_bus, poll_limit_set, q));
		if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
		e.item = q;
		e.gap = tx_calm ? 0 : $urandom_range(0, 9);
		e.hold_for_drain = next_drain || ($urandom_range(0, 79) == 0);
		next_drain = 1'b0;
		pending_reqs.push_back(e);
		planned++;
	endfunction

	// Plain ticks between operations, including the unused function codes.
	function automatic void plan_idle(int n);
		req_item_t q;
		for (int i = 0; i < n; i++) begin
			q.addr = 8'($urandom);
			q.wdata = 16'($urandom);
			q.miso = 1'($urandom);
			case ($urandom_range(0, 2))
			0: q.func = FN_TICK;
			1: q.func = FN_SPARE_A;
			default: q.func = FN_SPARE_B;
			endcase
			plan_push(q);
		end
	endfunction

	// A request followed by ticks until the sequencer is idle again. Noise puts
	// further codes on the ticks; the core refuses those that are requests unless finishing.
	function automatic void plan_op(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
			logic [WDATA_W-1:0] d, miso_plan_t miso_plan, int noise_pct);
		req_item_t q;
		int        polls;
		q.func = f;
		q.addr = a;
		q.wdata = d;
		q.miso = 1'($urandom);
		polls = 0;
		plan_push(q);
		while (plan_bus.stage != SEQ_IDLE) begin
			q.func = FN_TICK;
			if ($urandom_range(1, 100) <= noise_pct) q.func = 3'($urandom_range(1, 7));
			q.addr = 8'($urandom);
			q.wdata = 16'($urandom);
			q.miso = 1'($urandom);
			if (plan_bus.stage == SEQ_POLL && !plan_bus.sk_high) begin
				case (miso_plan)
				MISO_HIGH: q.miso = 1'b1;
				MISO_LOW: q.miso = 1'b0;
				default: q.miso = (polls >= 30) || ($urandom_range(0, 3) == 0);
				endcase
				polls++;
			end else if (plan_bus.stage == SEQ_IN && miso_plan != MISO_RANDOM) begin
				q.miso = (miso_plan == MISO_HIGH);
			end
			plan_push(q);
		end
	endfunction

	function automatic void plan_random(int unsigned n);
		int unsigned       target;
		int                noise;
		miso_plan_t        mp;
		logic [FUNC_W-1:0] f;
		target = planned + n;
		while (planned < target) begin
			case ($urandom_range(0, 11))
			0, 1: f = FN_TICK;
			2, 3, 4: f = FN_READ;
			5, 6, 7: f = FN_WRITE;
			8, 9: f = FN_ERASE;
			10: f = FN_WEN;
			default: f = FN_WDS;
			endcase
			if (f == FN_TICK) plan_idle($urandom_range(1, 4));
			else begin
				case ($urandom_range(0, 5))
				4: mp = MISO_HIGH;
				5: mp = MISO_LOW;
				default: mp = MISO_RANDOM;
				endcase
				// A silent device only makes sense when the limit is short.
				if (mp == MISO_LOW && f != FN_READ && poll_limit_set > 64) mp = MISO_RANDOM;
				if ($urandom_range(0, 9) < 7) noise = 0;
				else noise = ($urandom_range(0, 2) == 0) ? 60 : 10;
				plan_op(f, 8'($urandom), 16'($urandom), mp, noise);
			end
		end
	endfunction

	task automatic write_poll_limit(input logic [POLL_W-1:0] v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.poll_limit <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		poll_limit_set = v;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		while (phases_checked < planned) @(negedge clk);
	endtask

	function automatic void check_field(string fname, logic [15:0] got,
			logic [15:0] want);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
			mismatches++;
		end
	endfunction

	// Request side: presents planned items and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		bit          accepted;
		int unsigned predicted_now;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			gap_waited <= 0;
			phases_predicted <= 0;
		end else begin
			accepted = req_ch.valid && req_ch.ready;
			predicted_now = phases_predicted;
			if (accepted) begin
				bus_phase_expected[phases_predicted] = predict_bus_phase(live_bus,
					poll_limit_set, '{func: req_ch.func, addr: req_ch.addr,
					wdata: req_ch.wdata, miso: req_ch.miso});
				predicted_now = phases_predicted + 1;
				phases_predicted <= predicted_now;
			end
			if (!req_ch.valid || accepted) begin
				if (pending_reqs.size() == 0) req_ch.valid <= 1'b0;
				else if (gap_waited < pending_reqs[0].gap ||
						(pending_reqs[0].hold_for_drain && phases_checked != predicted_now)) begin
					req_ch.valid <= 1'b0;
					gap_waited <= gap_waited + 1;
				end else begin
					req_ch.valid <= 1'b1;
					req_ch.func <= pending_reqs[0].item.func;
					req_ch.addr <= pending_reqs[0].item.addr;
					req_ch.wdata <= pending_reqs[0].item.wdata;
					req_ch.miso <= pending_reqs[0].item.miso;
					void'(pending_reqs.pop_front());
					gap_waited <= 0;
				end
			end
		end
	end

	// Result side: random stalls and an in-order comparison.
	always @(posedge clk or negedge arst_n) begin
		int unsigned stall;
		res_item_t   want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			phases_checked <= 0;
			rx_hold <= 0;
		end else if (res_ch.valid && res_ch.ready) begin
			if (phases_checked >= phases_predicted) begin
				$display("%0t: unexpected result, expected none, got cs %b sk %b di %b status %0d",
					$time, res_ch.cs, res_ch.sk, res_ch.di, res_ch.status);
				mismatches++;
			end else begin
				want = bus_phase_expected[phases_checked];
				bus_phase_expected.delete(phases_checked);
				check_field("cs", 16'(res_ch.cs), 16'(want.cs));
				check_field("sk", 16'(res_ch.sk), 16'(want.sk));
				check_field("di", 16'(res_ch.di), 16'(want.di));
				check_field("busy_res", 16'(res_ch.busy_res), 16'(want.busy_res));
				check_field("done_res", 16'(res_ch.done_res), 16'(want.done_res));
				check_field("rdata", res_ch.rdata, want.rdata);
				check_field("status", 16'(res_ch.status), 16'(want.status));
			end
			phases_checked <= phases_checked + 1;
			if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 9);
			if (stall == 0) res_ch.ready <= 1'b1;
			else begin
				res_ch.ready <= 1'b0;
				rx_hold <= stall - 1;
			end
		end else if (!res_ch.ready) begin
			if (rx_hold == 0) res_ch.ready <= 1'b1;
			else rx_hold <= rx_hold - 1;
		end
	end

	initial begin
		logic [POLL_W-1:0] lim;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FN_TICK;
		req_ch.addr = '0;
		req_ch.wdata = '0;
		req_ch.miso = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.poll_limit = '0;
		poll_limit_set = '1;
		plan_bus = '0;
		live_bus = '0;
		planned = 0;
		mismatches = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		next_drain = 1'b0;

		// Directed operations under the reset poll limit.
		plan_op(FN_WEN, 8'h00, 16'h0000, MISO_RANDOM, 0);
		plan_op(FN_WDS, 8'hff, 16'hffff, MISO_RANDOM, 0);
		plan_op(FN_READ, 8'h00, 16'h0000, MISO_HIGH, 0);
		plan_op(FN_READ, 8'hff, 16'hffff, MISO_LOW, 0);
		plan_op(FN_WRITE, 8'h00, 16'hffff, MISO_HIGH, 0);
		plan_op(FN_WRITE, 8'hff, 16'h0000, MISO_RANDOM, 0);
		next_drain = 1'b1;
		plan_op(FN_ERASE, 8'h5a, 16'h1234, MISO_RANDOM, 0);
		plan_idle(4);
		// Every tick carries a nonzero function code, the finishing one included.
		plan_op(FN_READ, 8'ha5, 16'h5a5a, MISO_RANDOM, 100);
		plan_op(FN_WRITE, 8'h3c, 16'ha5c3, MISO_RANDOM, 100);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait_for_results();

		// A zero limit times out at the first busy sample.
		write_poll_limit(16'd0);
		plan_op(FN_ERASE, 8'h80, 16'h0000, MISO_LOW, 0);
		plan_op(FN_WRITE, 8'h01, 16'h8001, MISO_HIGH, 0);
		wait_for_results();

		write_poll_limit(16'd1);
		plan_op(FN_WRITE, 8'h7f, 16'h7ffe, MISO_LOW, 0);
		plan_op(FN_ERASE, 8'hfe, 16'h0000, MISO_RANDOM, 10);
		wait_for_results();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: lim = 16'($urandom_range(2, 40));
			1: lim = '1;
			2: lim = 16'($urandom_range(41, 65534));
			default: lim = 16'd1;
			endcase
			write_poll_limit(lim);
			plan_random(130);
			wait_for_results();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && phases_checked == phases_predicted) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
